// ===== sv/tqle_pkg.sv =====
// shared widths, types, codes and reset values of the q-learning engine
`timescale 1ns / 1ps
`default_nettype none

package tqle_pkg;

	// fixed field widths
	localparam int STATE_IDX_W = 10;
	localparam int ACTION_W    = 2;
	localparam int FIX_W       = 32;
	localparam int FRAC_W      = 16;
	localparam int RATIO_W     = 17;
	localparam int CFG_IDX_W   = 2;

	// default table geometry
	localparam int NUM_STATES_DEF   = 1024;
	localparam int ACTION_COUNT_DEF = 4;

	typedef logic [STATE_IDX_W-1:0]  state_idx_t;
	typedef logic [ACTION_W-1:0]     action_t;
	typedef logic signed [FIX_W-1:0] fix_t;
	typedef logic [FRAC_W-1:0]       frac_t;
	typedef logic [RATIO_W-1:0]      ratio_t;
	typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

	// operation codes
	typedef enum logic [0:0] {
		OP_CHOOSE     = 1'b0,
		OP_TRANSITION = 1'b1
	} opcode_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EPSILON       = 2'd0,
		CFG_LEARNING_RATE = 2'd1,
		CFG_DISCOUNT      = 2'd2
	} cfg_reg_t;

	// fraction one and register reset values
	localparam ratio_t ONE_FIX         = 17'd65536;
	localparam ratio_t EPSILON_RST     = 17'd6554;
	localparam ratio_t LEARN_RATE_RST  = 17'd6554;
	localparam ratio_t DISCOUNT_RST    = 17'd58982;

endpackage

`default_nettype wire

// ===== sv/tqle_cmd_if.sv =====
// input item channel of the q-learning engine
`timescale 1ns / 1ps
`default_nettype none

interface tqle_cmd_if;
	logic                   valid;
	logic                   ready;
	tqle_pkg::opcode_t      opcode;
	tqle_pkg::state_idx_t   current_state;
	tqle_pkg::action_t      taken_action;
	tqle_pkg::fix_t         reward;
	tqle_pkg::state_idx_t   reached_state;
	logic                   episode_done;
	tqle_pkg::frac_t        random_fraction;

	modport source (
		output valid, opcode, current_state, taken_action, reward, reached_state,
			episode_done, random_fraction,
		input  ready
	);
	modport sink (
		input  valid, opcode, current_state, taken_action, reward, reached_state,
			episode_done, random_fraction,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/tqle_res_if.sv =====
// result item channel of the q-learning engine
`timescale 1ns / 1ps
`default_nettype none

interface tqle_res_if;
	logic                valid;
	logic                ready;
	tqle_pkg::action_t   chosen_action;
	tqle_pkg::fix_t      updated_value;
	logic                saturated;

	modport source (
		output valid, chosen_action, updated_value, saturated,
		input  ready
	);
	modport sink (
		input  valid, chosen_action, updated_value, saturated,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/tqle_cfg_if.sv =====
// register write channel of the q-learning engine
`timescale 1ns / 1ps
`default_nettype none

interface tqle_cfg_if;
	logic                 valid;
	logic                 ready;
	tqle_pkg::cfg_idx_t   index;
	tqle_pkg::ratio_t     data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/tabular_q_learning_engine_top.sv =====
// tabular q-learning engine: q table memory, epsilon-greedy pick and update datapath
//
//  channel | dir | handshake     | beat contents
//  cmd     | in  | valid / ready | opcode, current_state, taken_action, reward,
//          |     |               | reached_state, episode_done, random_fraction
//  res     | out | valid / ready | chosen_action, updated_value, saturated
//  cfg     | in  | valid / ready | index, data (epsilon, learning_rate, discount_factor)
//
// one item at a time; the row scan reads one table entry per cycle from the read port:
// a choose steps through prep, scan and out; a transition through prep, scan (skipped
// when done), qrd, qget, delta, mul and out; idle comes before the next beat is taken
// after reset a clearing pass zeroes 2**(clog2(NUM_STATES)+clog2(ACTION_COUNT))
// entries (4096 by default), one per cycle, before cmd.ready rises
// a finished result waits in the output register; the next item holds in its last step
`timescale 1ns / 1ps
`default_nettype none

module tabular_q_learning_engine_top #(
	parameter int NUM_STATES   = tqle_pkg::NUM_STATES_DEF,
	parameter int ACTION_COUNT = tqle_pkg::ACTION_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tqle_cmd_if.sink         cmd,
	tqle_res_if.source       res,
	tqle_cfg_if.sink         cfg
);

	localparam int STATE_W    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int ACT_W      = (ACTION_COUNT > 1) ? $clog2(ACTION_COUNT) : 1;
	localparam int ADDR_W     = STATE_W + ACT_W;
	localparam int MEM_DEPTH  = 2 ** ADDR_W;
	localparam int CUM_W      = tqle_pkg::RATIO_W + 1 + ACT_W;
	localparam int IN_STATE_W = tqle_pkg::STATE_IDX_W;
	localparam int OUT_ACT_W  = tqle_pkg::ACTION_W;
	localparam int FIX_W      = tqle_pkg::FIX_W;
	localparam int COEF_W     = tqle_pkg::RATIO_W + 1;
	localparam int PROD1_W    = COEF_W + FIX_W;
	localparam int TGT_W      = FIX_W + 2;
	localparam int PROD2_W    = COEF_W + TGT_W;
	localparam int NQ_W       = TGT_W + 2;

	localparam logic signed [NQ_W-1:0] NQ_MAX = NQ_W'(64'sd2147483647);
	localparam logic signed [NQ_W-1:0] NQ_MIN = NQ_W'(-64'sd2147483648);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_PREP  = 9'b000000100,
		S_SCAN  = 9'b000001000,
		S_QRD   = 9'b000010000,
		S_QGET  = 9'b000100000,
		S_DELTA = 9'b001000000,
		S_MUL   = 9'b010000000,
		S_OUT   = 9'b100000000
	} fsm_t;

	// state index modulo NUM_STATES by shifted compare and subtract
	function automatic logic [IN_STATE_W-1:0] state_mod(input logic [IN_STATE_W-1:0] s);
		logic [IN_STATE_W-1:0] v;
		v = s;
		for (int k = IN_STATE_W - 1; k >= 0; k--) begin
			if ((longint'(NUM_STATES) << k) < (longint'(1) << IN_STATE_W)) begin
				if (longint'(v) >= (longint'(NUM_STATES) << k)) begin
					v = v - IN_STATE_W'(longint'(NUM_STATES) << k);
				end
			end
		end
		return v;
	endfunction

	function automatic tqle_pkg::ratio_t clamp_one(input tqle_pkg::ratio_t v);
		return (v > tqle_pkg::ONE_FIX) ? tqle_pkg::ONE_FIX : v;
	endfunction

	fsm_t                         state_q;
	logic [ADDR_W-1:0]            clr_addr_q;
	tqle_pkg::ratio_t             eps_q, alpha_q, gamma_q;

	// captured item
	tqle_pkg::opcode_t            op_q;
	tqle_pkg::state_idx_t         cur_raw_q, nxt_raw_q;
	tqle_pkg::action_t            act_raw_q;
	tqle_pkg::fix_t               reward_q;
	logic                         done_q;
	tqle_pkg::frac_t              rnd_q;

	// folded indexes and selection bounds
	logic [STATE_W-1:0]           cur_row_q, scan_row_q;
	logic [ACT_W-1:0]             act_q;
	logic [CUM_W-1:0]             lhs_q, kfix_q, acc_q;

	// row scan
	logic [ACT_W-1:0]             iss_idx_q, chk_idx_q;
	logic                         chk_vld_q;
	tqle_pkg::fix_t               best_q;
	logic [ACT_W-1:0]             g_q, i0_q, i1_q;
	logic                         f0_q, f1_q;

	// update datapath
	logic signed [PROD1_W-1:0]    prod1_q;
	tqle_pkg::fix_t               q_q;
	logic signed [TGT_W-1:0]      target_q, delta_q;
	logic signed [PROD2_W-1:0]    prod2_q;

	// table memory
	tqle_pkg::fix_t               qmem [MEM_DEPTH];
	tqle_pkg::fix_t               rdata_q;
	logic [ADDR_W-1:0]            raddr, waddr;
	logic                         mem_we;
	tqle_pkg::fix_t               wdata;

	// output register
	logic                         res_vld_q;
	tqle_pkg::action_t            res_act_q;
	tqle_pkg::fix_t               res_val_q;
	logic                         res_sat_q;

	logic                         cmd_fire, out_free, scan_last;
	logic [ACT_W-1:0]             act_mod, sel;
	logic [IN_STATE_W-1:0]        cur_fold, nxt_fold;
	logic [CUM_W-1:0]             acc_n;
	logic                         hit0, hit1, greater;
	logic signed [TGT_W-1:0]      rnd1, target_n;
	logic signed [PROD1_W-1:0]    sum1;
	logic signed [PROD2_W-1:0]    sum2;
	logic signed [NQ_W-1:0]       rnd2, nq;
	tqle_pkg::fix_t               nq_sat;
	logic                         nq_ovf;
	logic signed [COEF_W-1:0]     gamma_s, alpha_s;

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign out_free  = !res_vld_q || res.ready;
	assign scan_last = chk_vld_q && (chk_idx_q == ACT_W'(ACTION_COUNT - 1));

	assign res.valid         = res_vld_q;
	assign res.chosen_action = res_act_q;
	assign res.updated_value = res_val_q;
	assign res.saturated     = res_sat_q;

	// index folding
	always_comb begin
		logic [31:0] a;
		a = 32'(act_raw_q);
		if (a >= 32'(ACTION_COUNT)) begin
			a = a - 32'(ACTION_COUNT);
		end
		act_mod  = ACT_W'(a);
		cur_fold = state_mod(cur_raw_q);
		nxt_fold = state_mod(nxt_raw_q);
	end

	// scan compare and cumulative share tests
	assign acc_n   = acc_q + CUM_W'(eps_q);
	assign hit0    = lhs_q < acc_n;
	assign hit1    = lhs_q < (acc_n + kfix_q);
	assign greater = (chk_idx_q == '0) || (rdata_q > best_q);

	// epsilon-greedy pick from first hits and greedy action
	always_comb begin
		if (f0_q && (i0_q < g_q)) begin
			sel = i0_q;
		end else if (f1_q) begin
			sel = (i1_q > g_q) ? i1_q : g_q;
		end else begin
			sel = '0;
		end
	end

	// rounding, update sum and clipping
	always_comb begin
		gamma_s  = $signed({1'b0, gamma_q});
		alpha_s  = $signed({1'b0, alpha_q});
		sum1     = prod1_q + PROD1_W'(64'sd32768);
		rnd1     = TGT_W'(sum1 >>> 16);
		target_n = done_q ? TGT_W'(reward_q) : (TGT_W'(reward_q) + rnd1);
		sum2     = prod2_q + PROD2_W'(64'sd32768);
		rnd2     = NQ_W'(sum2 >>> 16);
		nq       = NQ_W'(q_q) + rnd2;
		nq_ovf   = (nq > NQ_MAX) || (nq < NQ_MIN);
		if (nq > NQ_MAX) begin
			nq_sat = FIX_W'(NQ_MAX);
		end else if (nq < NQ_MIN) begin
			nq_sat = FIX_W'(NQ_MIN);
		end else begin
			nq_sat = FIX_W'(nq);
		end
	end

	// memory port selection
	always_comb begin
		raddr  = (state_q == S_QRD) ? {cur_row_q, act_q} : {scan_row_q, iss_idx_q};
		mem_we = (state_q == S_CLEAR) ||
			((state_q == S_OUT) && out_free && (op_q == tqle_pkg::OP_TRANSITION));
		waddr  = (state_q == S_CLEAR) ? clr_addr_q : {cur_row_q, act_q};
		wdata  = (state_q == S_CLEAR) ? '0 : nq_sat;
	end

	// q table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			qmem[waddr] <= wdata;
		end
		rdata_q <= qmem[raddr];
	end

	// control, registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			iss_idx_q  <= '0;
			chk_vld_q  <= 1'b0;
			f0_q       <= 1'b0;
			f1_q       <= 1'b0;
			res_vld_q  <= 1'b0;
			eps_q      <= tqle_pkg::EPSILON_RST;
			alpha_q    <= tqle_pkg::LEARN_RATE_RST;
			gamma_q    <= tqle_pkg::DISCOUNT_RST;
		end else begin
			// register writes
			if (cfg.valid) begin
				unique case (cfg.index)
					tqle_pkg::CFG_EPSILON:       eps_q   <= clamp_one(cfg.data);
					tqle_pkg::CFG_LEARNING_RATE: alpha_q <= clamp_one(cfg.data);
					tqle_pkg::CFG_DISCOUNT:      gamma_q <= clamp_one(cfg.data);
					default: ;
				endcase
			end

			// output valid: set by the final step, cleared when the beat is taken
			if ((state_q == S_OUT) && out_free) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_fire) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					iss_idx_q <= '0;
					chk_vld_q <= 1'b0;
					f0_q      <= 1'b0;
					f1_q      <= 1'b0;
					if ((op_q == tqle_pkg::OP_TRANSITION) && done_q) begin
						state_q <= S_QRD;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					iss_idx_q <= iss_idx_q + ACT_W'(1);
					chk_vld_q <= !scan_last;
					if (chk_vld_q) begin
						if (!f0_q && hit0) begin
							f0_q <= 1'b1;
						end
						if (!f1_q && hit1) begin
							f1_q <= 1'b1;
						end
					end
					if (scan_last) begin
						state_q <= (op_q == tqle_pkg::OP_CHOOSE) ? S_OUT : S_QRD;
					end
				end
				S_QRD:   state_q <= S_QGET;
				S_QGET:  state_q <= S_DELTA;
				S_DELTA: state_q <= S_MUL;
				S_MUL:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath and payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_q      <= cmd.opcode;
			cur_raw_q <= cmd.current_state;
			act_raw_q <= cmd.taken_action;
			reward_q  <= cmd.reward;
			nxt_raw_q <= cmd.reached_state;
			done_q    <= cmd.episode_done;
			rnd_q     <= cmd.random_fraction;
		end

		// fold indexes and scale the selection bounds
		if (state_q == S_PREP) begin
			cur_row_q  <= STATE_W'(cur_fold);
			scan_row_q <= (op_q == tqle_pkg::OP_CHOOSE) ? STATE_W'(cur_fold)
				: STATE_W'(nxt_fold);
			act_q      <= act_mod;
			lhs_q      <= CUM_W'(rnd_q) * CUM_W'(ACTION_COUNT);
			kfix_q     <= CUM_W'(tqle_pkg::ONE_FIX - eps_q) * CUM_W'(ACTION_COUNT);
			acc_q      <= '0;
		end

		// one row entry per cycle: first maximum and first hits
		if (state_q == S_SCAN) begin
			chk_idx_q <= iss_idx_q;
			if (chk_vld_q) begin
				acc_q <= acc_n;
				if (greater) begin
					best_q <= rdata_q;
					g_q    <= chk_idx_q;
				end
				if (!f0_q && hit0) begin
					i0_q <= chk_idx_q;
				end
				if (!f1_q && hit1) begin
					i1_q <= chk_idx_q;
				end
			end
		end

		// discounted next-state value
		if (state_q == S_QRD) begin
			prod1_q <= gamma_s * best_q;
		end

		if (state_q == S_QGET) begin
			q_q      <= rdata_q;
			target_q <= target_n;
		end

		if (state_q == S_DELTA) begin
			delta_q <= target_q - TGT_W'(q_q);
		end

		// learning step
		if (state_q == S_MUL) begin
			prod2_q <= alpha_s * delta_q;
		end

		// result beat
		if ((state_q == S_OUT) && out_free) begin
			if (op_q == tqle_pkg::OP_CHOOSE) begin
				res_act_q <= OUT_ACT_W'(sel);
				res_val_q <= '0;
				res_sat_q <= 1'b0;
			end else begin
				res_act_q <= done_q ? '0 : OUT_ACT_W'(sel);
				res_val_q <= nq_sat;
				res_sat_q <= nq_ovf;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// an accepted beat always goes on to index folding
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> state_q == S_PREP)
		else $error("accepted beat did not enter fold step");

	// a clipped result sits at one end of the 32-bit range
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.saturated) |->
			(res.updated_value == 32'sh7fffffff) || (res.updated_value == 32'sh80000000))
		else $error("saturated result not at a range limit");

	// picked action lies within the row
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> 32'(res.chosen_action) < 32'(ACTION_COUNT))
		else $error("chosen action beyond action count");

	// a new result only follows the final step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside final step");
`endif

endmodule

`default_nettype wire
